/* rtl/core/mtce_pkg.sv */
// Shared types and constants of the Modbus TCP client transaction engine.
// No dependencies; used by every module of the engine.
package mtce_pkg;

    localparam int QueueDepth = 4;

    localparam int FuncW     = 3;
    localparam int ByteW     = 8;
    localparam int WordW     = 16;
    localparam int IdxW      = 11;
    localparam int StatW     = 4;
    localparam int PosW      = 9;
    localparam int StepW     = 4;
    localparam int InDataW   = 56;
    localparam int OutDataW  = 48;

    localparam logic [FuncW-1:0] FN_RD_REG  = 3'd0;
    localparam logic [FuncW-1:0] FN_WR_REG  = 3'd1;
    localparam logic [FuncW-1:0] FN_RD_COIL = 3'd2;
    localparam logic [FuncW-1:0] FN_WR_COIL = 3'd3;
    localparam logic [FuncW-1:0] FN_RX      = 3'd4;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_REG    = 2'd1;
    localparam logic [1:0] KIND_COIL   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [StatW-1:0] ST_OK        = 4'd0;
    localparam logic [StatW-1:0] ST_COUNT     = 4'd1;
    localparam logic [StatW-1:0] ST_TXID      = 4'd2;
    localparam logic [StatW-1:0] ST_PROTO     = 4'd3;
    localparam logic [StatW-1:0] ST_LENGTH    = 4'd4;
    localparam logic [StatW-1:0] ST_EXCEPTION = 4'd5;
    localparam logic [StatW-1:0] ST_FC_ECHO   = 4'd6;
    localparam logic [StatW-1:0] ST_TRUNC     = 4'd7;
    localparam logic [StatW-1:0] ST_BYTECOUNT = 4'd8;
    localparam logic [StatW-1:0] ST_ECHO_SIZE = 4'd9;

    localparam logic [7:0]  EXC_BIT   = 8'h80;
    localparam logic [15:0] COIL_ON   = 16'hFF00;
    localparam logic [15:0] MAX_REGS  = 16'd125;
    localparam logic [15:0] MAX_COILS = 16'd2000;
    localparam logic [15:0] MAX_LEN   = 16'd260;

    typedef struct packed {
        logic             frame;
        logic [WordW-1:0] txid;
        logic [ByteW-1:0] unit;
        logic [ByteW-1:0] fc;
        logic [WordW-1:0] addr;
        logic [WordW-1:0] word;
        logic             reg_en;
        logic [StepW-1:0] coil_cnt;
        logic [ByteW-1:0] coil_byte;
        logic [IdxW-1:0]  idx;
        logic             st_en;
        logic [StatW-1:0] st;
        logic [ByteW-1:0] exc;
        logic             drop;
    } job_t;

    function automatic logic [7:0] fcode(input logic [1:0] fn);
        logic [7:0] c;
        case (fn)
            2'd0:    c = 8'h03;
            2'd1:    c = 8'h06;
            2'd2:    c = 8'h01;
            default: c = 8'h05;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/mtce_queue.sv */
// Small job queue between the front and back parts of the engine.
// Depends on mtce_pkg for the job type.
module mtce_queue #(
    parameter int DEPTH = mtce_pkg::QueueDepth
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mtce_pkg::job_t din,
    output logic           full,
    input  logic           pop,
    output mtce_pkg::job_t dout,
    output logic           avail
);
    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    mtce_pkg::job_t mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full  = (count_reg == CntW'(DEPTH));
    assign avail = (count_reg != '0);
    assign dout  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/mtce_front.sv */
// Front part: accepts requests and received bytes, keeps transaction and
// parse state, and turns each accepted item into at most one job. Depends on mtce_pkg.
module mtce_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [7:0]                    cfg_wdata,
    input  logic                          accept,
    input  logic [mtce_pkg::FuncW-1:0]    func,
    input  logic [15:0]                   address,
    input  logic [15:0]                   quantity,
    input  logic [15:0]                   write_value,
    input  logic [7:0]                    rx_byte,
    output logic                          push,
    output mtce_pkg::job_t                job
);
    typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_PDU, PH_DRAIN} phase_t;

    phase_t                      phase_reg, phase_next;
    logic [7:0]                  unit_reg;
    logic [15:0]                 txc_reg, txc_next;
    logic [15:0]                 exp_reg, exp_next;
    logic [1:0]                  pfn_reg, pfn_next;
    logic [mtce_pkg::IdxW-1:0]   pqty_reg, pqty_next;
    logic [mtce_pkg::PosW-1:0]   bpos_reg, bpos_next;
    logic [mtce_pkg::PosW-1:0]   plen_reg, plen_next;
    logic [47:0]                 hdr_reg, hdr_next;
    logic [15:0]                 rf_reg, rf_next;
    logic [mtce_pkg::IdxW-1:0]   oidx_reg, oidx_next;

    logic [7:0]                  fc;
    logic                        is_read;
    logic [mtce_pkg::PosW-1:0]   p;
    logic [11:0]                 want;
    logic [mtce_pkg::IdxW-1:0]   remain;
    logic [mtce_pkg::StepW-1:0]  cnt;
    logic [15:0]                 rln;
    logic                        bad_qty;

    assign fc      = mtce_pkg::fcode(pfn_reg);
    assign is_read = !pfn_reg[0];
    assign p       = bpos_reg + 1'b1;
    assign want    = (pfn_reg == 2'd0) ? {pqty_reg, 1'b0}
                                       : 12'((12'(pqty_reg) + 12'd7) >> 3);
    assign remain  = pqty_reg - oidx_reg;
    assign cnt     = (oidx_reg >= pqty_reg) ? '0
                   : (remain >= 11'd8) ? 4'd8 : remain[3:0];
    assign rln     = hdr_reg[15:0];
    assign bad_qty = (func == mtce_pkg::FN_RD_REG
                        && (quantity == 16'd0 || quantity > mtce_pkg::MAX_REGS))
                  || (func == mtce_pkg::FN_RD_COIL
                        && (quantity == 16'd0 || quantity > mtce_pkg::MAX_COILS));

    always_comb
    begin
        phase_next = phase_reg;
        txc_next   = txc_reg;
        exp_next   = exp_reg;
        pfn_next   = pfn_reg;
        pqty_next  = pqty_reg;
        bpos_next  = bpos_reg;
        plen_next  = plen_reg;
        hdr_next   = hdr_reg;
        rf_next    = rf_reg;
        oidx_next  = oidx_reg;
        job        = '0;
        if (accept)
        begin
            if (func <= mtce_pkg::FN_WR_COIL)
            begin
                phase_next = PH_IDLE;
                if (bad_qty)
                begin
                    job.st_en = 1'b1;
                    job.st    = mtce_pkg::ST_COUNT;
                end
                else
                begin
                    job.frame = 1'b1;
                    job.txid  = txc_reg;
                    job.unit  = unit_reg;
                    job.fc    = mtce_pkg::fcode(func[1:0]);
                    job.addr  = address;
                    if (func == mtce_pkg::FN_WR_REG)
                    begin
                        job.word = write_value;
                    end
                    else if (func == mtce_pkg::FN_WR_COIL)
                    begin
                        job.word = (write_value != 16'd0) ? mtce_pkg::COIL_ON : 16'd0;
                    end
                    else
                    begin
                        job.word = quantity;
                    end
                    txc_next   = txc_reg + 1'b1;
                    exp_next   = txc_reg;
                    pfn_next   = func[1:0];
                    pqty_next  = func[0] ? '0 : quantity[10:0];
                    phase_next = PH_HEADER;
                    bpos_next  = '0;
                    plen_next  = '0;
                    hdr_next   = '0;
                    rf_next    = '0;
                    oidx_next  = '0;
                end
            end
            else if (func == mtce_pkg::FN_RX)
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (bpos_reg < 9'd6)
                        begin
                            hdr_next  = {hdr_reg[39:0], rx_byte};
                            bpos_next = p;
                        end
                        else if (hdr_reg[47:32] != exp_reg)
                        begin
                            phase_next = PH_IDLE;
                            job.st_en  = 1'b1;
                            job.st     = mtce_pkg::ST_TXID;
                            job.drop   = 1'b1;
                        end
                        else if (hdr_reg[31:16] != 16'd0)
                        begin
                            phase_next = PH_IDLE;
                            job.st_en  = 1'b1;
                            job.st     = mtce_pkg::ST_PROTO;
                            job.drop   = 1'b1;
                        end
                        else if (rln < 16'd2 || rln > mtce_pkg::MAX_LEN)
                        begin
                            phase_next = PH_IDLE;
                            job.st_en  = 1'b1;
                            job.st     = mtce_pkg::ST_LENGTH;
                            job.drop   = 1'b1;
                        end
                        else
                        begin
                            plen_next  = rln[8:0] - 1'b1;
                            bpos_next  = '0;
                            phase_next = PH_PDU;
                        end
                    end
                    PH_DRAIN:
                    begin
                        bpos_next = p;
                        if (p >= plen_reg)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_PDU:
                    begin
                        bpos_next = p;
                        if (p == 9'd1)
                        begin
                            rf_next = {8'd0, rx_byte};
                            if (rx_byte == (fc | mtce_pkg::EXC_BIT))
                            begin
                                if (plen_reg == 9'd1)
                                begin
                                    phase_next = PH_IDLE;
                                    job.st_en  = 1'b1;
                                    job.st     = mtce_pkg::ST_EXCEPTION;
                                end
                            end
                            else if (rx_byte != fc)
                            begin
                                phase_next = PH_IDLE;
                                job.st_en  = 1'b1;
                                job.st     = mtce_pkg::ST_FC_ECHO;
                                job.drop   = 1'b1;
                            end
                            else if (!is_read && plen_reg != 9'd5)
                            begin
                                phase_next = PH_IDLE;
                                job.st_en  = 1'b1;
                                job.st     = mtce_pkg::ST_ECHO_SIZE;
                                job.drop   = 1'b1;
                            end
                            else if (is_read && plen_reg < 9'd2)
                            begin
                                phase_next = PH_IDLE;
                                job.st_en  = 1'b1;
                                job.st     = mtce_pkg::ST_TRUNC;
                                job.drop   = 1'b1;
                            end
                        end
                        else if (p == 9'd2 && rf_reg[7:0] == (fc | mtce_pkg::EXC_BIT))
                        begin
                            phase_next = (plen_reg > 9'd2) ? PH_DRAIN : PH_IDLE;
                            job.st_en  = 1'b1;
                            job.st     = mtce_pkg::ST_EXCEPTION;
                            job.exc    = rx_byte;
                        end
                        else if (!is_read)
                        begin
                            if (p >= plen_reg)
                            begin
                                phase_next = PH_IDLE;
                                job.st_en  = 1'b1;
                                job.st     = mtce_pkg::ST_OK;
                            end
                        end
                        else if (p == 9'd2)
                        begin
                            if (12'(rx_byte) != want
                                || 10'(plen_reg) < 10'd2 + 10'(rx_byte))
                            begin
                                phase_next = PH_IDLE;
                                job.st_en  = 1'b1;
                                job.st     = mtce_pkg::ST_BYTECOUNT;
                                job.drop   = 1'b1;
                            end
                            else
                            begin
                                rf_next   = {rx_byte, 8'd0};
                                oidx_next = '0;
                            end
                        end
                        else
                        begin
                            if (pfn_reg == 2'd0)
                            begin
                                if (p[0])
                                begin
                                    rf_next = {rf_reg[15:8], rx_byte};
                                end
                                else
                                begin
                                    job.reg_en = 1'b1;
                                    job.word   = {rf_reg[7:0], rx_byte};
                                    job.idx    = oidx_reg;
                                    oidx_next  = oidx_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                job.coil_cnt  = cnt;
                                job.coil_byte = rx_byte;
                                job.idx       = oidx_reg;
                                oidx_next     = oidx_reg
                                    + {{(mtce_pkg::IdxW - mtce_pkg::StepW){1'b0}}, cnt};
                            end
                            if (10'(p) >= 10'd2 + 10'(rf_reg[15:8]))
                            begin
                                phase_next = (plen_reg > p) ? PH_DRAIN : PH_IDLE;
                                job.st_en  = 1'b1;
                                job.st     = mtce_pkg::ST_OK;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    assign push = job.frame || job.st_en || job.reg_en || (job.coil_cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            unit_reg  <= '0;
            txc_reg   <= '0;
            exp_reg   <= '0;
            pfn_reg   <= '0;
            pqty_reg  <= '0;
            bpos_reg  <= '0;
            plen_reg  <= '0;
            hdr_reg   <= '0;
            rf_reg    <= '0;
            oidx_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unit_reg <= cfg_wdata;
            end
            phase_reg <= phase_next;
            txc_reg   <= txc_next;
            exp_reg   <= exp_next;
            pfn_reg   <= pfn_next;
            pqty_reg  <= pqty_next;
            bpos_reg  <= bpos_next;
            plen_reg  <= plen_next;
            hdr_reg   <= hdr_next;
            rf_reg    <= rf_next;
            oidx_reg  <= oidx_next;
        end
    end

endmodule

/* rtl/core/mtce_back.sv */
// Back part: expands each queued job into result transfers, one per cycle while
// the output is not stalled, into a registered output stage. Depends on mtce_pkg.
module mtce_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              avail,
    input  mtce_pkg::job_t                    job,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mtce_pkg::OutDataW-1:0]     m_tdata,
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast
);
    logic [mtce_pkg::StepW-1:0]    step_reg;
    logic                          ov_reg;
    logic [mtce_pkg::OutDataW-1:0] data_reg;
    logic [1:0]                    kind_reg;
    logic                          last_reg;

    logic [mtce_pkg::StepW-1:0]    total;
    logic [mtce_pkg::StepW-1:0]    k;
    logic                          load;
    logic                          is_last;
    logic [1:0]                    kind;
    logic [7:0]                    txb;
    logic [15:0]                   dval;
    logic [mtce_pkg::IdxW-1:0]     idx;
    logic [mtce_pkg::StatW-1:0]    st;
    logic [7:0]                    exc;
    logic                          drop;

    assign total   = job.frame ? 4'd12
                   : 4'(job.reg_en) + job.coil_cnt + 4'(job.st_en);
    assign k       = step_reg - 4'(job.reg_en);
    assign is_last = (step_reg == total - 1'b1);
    assign load    = avail && (!ov_reg || m_tready);
    assign pop     = load && is_last;

    always_comb
    begin
        kind = mtce_pkg::KIND_STATUS;
        txb  = '0;
        dval = '0;
        idx  = '0;
        st   = '0;
        exc  = '0;
        drop = 1'b0;
        if (job.frame)
        begin
            kind = mtce_pkg::KIND_TX;
            case (step_reg)
                4'd0:    txb = job.txid[15:8];
                4'd1:    txb = job.txid[7:0];
                4'd5:    txb = 8'd6;
                4'd6:    txb = job.unit;
                4'd7:    txb = job.fc;
                4'd8:    txb = job.addr[15:8];
                4'd9:    txb = job.addr[7:0];
                4'd10:   txb = job.word[15:8];
                4'd11:   txb = job.word[7:0];
                default: txb = 8'd0;
            endcase
        end
        else if (job.reg_en && step_reg == '0)
        begin
            kind = mtce_pkg::KIND_REG;
            dval = job.word;
            idx  = job.idx;
        end
        else if (k < job.coil_cnt)
        begin
            kind = mtce_pkg::KIND_COIL;
            dval = {15'd0, job.coil_byte[k[2:0]]};
            idx  = job.idx + {{(mtce_pkg::IdxW - mtce_pkg::StepW){1'b0}}, k};
        end
        else
        begin
            st   = job.st;
            exc  = job.exc;
            drop = job.drop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else if (load)
        begin
            ov_reg   <= 1'b1;
            step_reg <= is_last ? '0 : step_reg + 1'b1;
        end
        else if (m_tready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {drop, exc, st, idx, dval, txb};
            kind_reg <= kind;
            last_reg <= is_last;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

/* rtl/core/modbus_tcp_client_engine_top.sv */
// Top level of the Modbus TCP client transaction engine.
// Depends on mtce_pkg, mtce_front, mtce_queue and mtce_back.
//
// channel  | dir | handshake          | payload
// s_       | in  | s_tvalid/s_tready  | tuser func, tdata address..rx_byte
// m_       | out | m_tvalid/m_tready  | tuser kind, tdata tx_byte..drop_link
// cfg_     | in  | cfg_we             | cfg_wdata unit_id
//
// Input items are taken one per cycle while the job queue has room.
// Results leave one per cycle while the output is not stalled; a request
// frame yields 12 transfers, a coil byte up to 9, so the back end sets the sustained rate.
// Reset clears all transaction and parse state and empties the queue.
// A stalled output holds its transfer; the queue absorbs up to QDEPTH jobs.
module modbus_tcp_client_engine_top #(
    parameter int QDEPTH = mtce_pkg::QueueDepth
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [7:0]                    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mtce_pkg::InDataW-1:0]  s_tdata,  // address, quantity,
                                                    //   write_value, rx_byte
    input  logic [mtce_pkg::FuncW-1:0]    s_tuser,  // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mtce_pkg::OutDataW-1:0] m_tdata,  // tx_byte, data_value, item_index,
                                                    //   status, exception_code, drop_link
    output logic [1:0]                    m_tuser,  // kind
    output logic                          m_tlast
);
    logic           full, push, pop, avail;
    mtce_pkg::job_t job_in, job_out;

    assign s_tready = !full;

    mtce_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .accept      (s_tvalid && !full),
        .func        (s_tuser),
        .address     (s_tdata[15:0]),
        .quantity    (s_tdata[31:16]),
        .write_value (s_tdata[47:32]),
        .rx_byte     (s_tdata[55:48]),
        .push        (push),
        .job         (job_in)
    );

    mtce_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (job_in),
        .full  (full),
        .pop   (pop),
        .dout  (job_out),
        .avail (avail)
    );

    mtce_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .avail    (avail),
        .job      (job_out),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/core/mtce_checker.sv */
// Port-level checks of the engine's result stream, bound to the top level.
// Depends on mtce_pkg and modbus_tcp_client_engine_top.
module mtce_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mtce_pkg::OutDataW-1:0]  m_tdata,
    input logic [1:0]                     m_tuser,
    input logic                           m_tlast
);
    // hold a stalled transfer
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled transfer changed");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == mtce_pkg::KIND_STATUS |-> m_tlast)
        else $error("status not last");

    a_drop_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[47] |-> m_tuser == mtce_pkg::KIND_STATUS)
        else $error("drop_link on non-status");

    a_tx_follow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser == mtce_pkg::KIND_TX && !m_tlast
        |=> m_tvalid && m_tuser == mtce_pkg::KIND_TX)
        else $error("frame broken");

endmodule

bind modbus_tcp_client_engine_top mtce_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
